[sv/csff_pkg.sv]
// ----------------------------------------------------------------------------
// csff_pkg
// Shared types, constants and helpers of the shifted complex FIR filter.
// ----------------------------------------------------------------------------
package csff_pkg;

  localparam int MAX_TAPS    = 1024;
  localparam int ADDR_BITS   = $clog2(MAX_TAPS);
  localparam int TAP_CNT_BITS = ADDR_BITS + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam int TRIG_BITS   = 18;
  localparam int NCO_FRAC    = 16;
  localparam int NCO_ONE     = 65536;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W    = 20;
  localparam int ANGLE_W     = 33;
  localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS    = PROD_BITS + ADDR_BITS + 1;
  localparam int RND_BITS    = 48;

  localparam logic [1:0] REG_NUM_TAPS     = 2'd0;
  localparam logic [1:0] REG_COMPLEX_MODE = 2'd1;
  localparam logic [1:0] REG_PHASE_STEP   = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NCO, ST_ROT, ST_WR_HIST, ST_FIR, ST_DONE
  } state_t;

  typedef struct packed {
    logic                        done;
    logic signed [TRIG_BITS-1:0] cos_v;
    logic signed [TRIG_BITS-1:0] sin_v;
  } nco_out_t;

  function automatic logic signed [ANGLE_W-1:0] arc_angle(input logic [3:0] i);
    logic [31:0] a;
    unique case (i)
      4'd0:  a = 32'h20000000;
      4'd1:  a = 32'h12E4051E;
      4'd2:  a = 32'h09FB385B;
      4'd3:  a = 32'h051111D4;
      4'd4:  a = 32'h028B0D43;
      4'd5:  a = 32'h0145D7E1;
      4'd6:  a = 32'h00A2F61E;
      4'd7:  a = 32'h00517C55;
      4'd8:  a = 32'h0028BE53;
      4'd9:  a = 32'h00145F2F;
      4'd10: a = 32'h000A2F98;
      4'd11: a = 32'h000517CC;
      4'd12: a = 32'h00028BE6;
      4'd13: a = 32'h000145F3;
      4'd14: a = 32'h0000A2FA;
      default: a = 32'h0000517D;
    endcase
    return signed'({1'b0, a});
  endfunction

  // Round half up by sh bits, then saturate; result is {clip, value}.
  function automatic logic [SAMPLE_BITS:0] round_sat(input logic signed [RND_BITS-1:0] v,
                                                     input int unsigned sh);
    logic signed [RND_BITS-1:0] t;
    logic signed [RND_BITS-1:0] hi;
    logic signed [RND_BITS-1:0] lo;
    t  = (v + (RND_BITS'(1) <<< (sh - 1))) >>> sh;
    hi = RND_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    lo = -hi - RND_BITS'(1);
    if (t > hi) return {1'b1, hi[SAMPLE_BITS-1:0]};
    if (t < lo) return {1'b1, lo[SAMPLE_BITS-1:0]};
    return {1'b0, t[SAMPLE_BITS-1:0]};
  endfunction

endpackage

[sv/csff_nco.sv]
// ----------------------------------------------------------------------------
// csff_nco
// Iterative CORDIC: one micro-rotation a cycle, then quadrant unfold.
// ----------------------------------------------------------------------------
module csff_nco (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           phase,
  output csff_pkg::nco_out_t    nco_out
);
  import csff_pkg::*;

  logic signed [CORDIC_W-1:0] x, y, xc, yc;
  logic signed [ANGLE_W-1:0]  z;
  logic [3:0]                 step;
  logic [1:0]                 quad;
  logic                       busy, fin;

  always_comb begin
    xc = x;
    yc = y;
    if (x > CORDIC_W'(NCO_ONE)) xc = CORDIC_W'(NCO_ONE);
    if (x < -CORDIC_W'(NCO_ONE)) xc = -CORDIC_W'(NCO_ONE);
    if (y > CORDIC_W'(NCO_ONE)) yc = CORDIC_W'(NCO_ONE);
    if (y < -CORDIC_W'(NCO_ONE)) yc = -CORDIC_W'(NCO_ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      nco_out.done <= 1'b0;
    end else begin
      nco_out.done <= fin;
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        quad <= phase[31:30];
        x <= CORDIC_W'(28141);
        y <= CORDIC_W'(28141);
        z <= signed'(ANGLE_W'(phase[29:0])) - ANGLE_W'(32'h20000000);
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - arc_angle(step);
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + arc_angle(step);
        end
        step <= step + 4'd1;
        if (step == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        unique case (quad)
          2'd0: begin
            nco_out.cos_v <= TRIG_BITS'(xc);  nco_out.sin_v <= TRIG_BITS'(yc);
          end
          2'd1: begin
            nco_out.cos_v <= TRIG_BITS'(-yc); nco_out.sin_v <= TRIG_BITS'(xc);
          end
          2'd2: begin
            nco_out.cos_v <= TRIG_BITS'(-xc); nco_out.sin_v <= TRIG_BITS'(-yc);
          end
          default: begin
            nco_out.cos_v <= TRIG_BITS'(yc);  nco_out.sin_v <= TRIG_BITS'(-xc);
          end
        endcase
      end
    end
  end

endmodule

[sv/complex_shifted_fir_filter_top.sv]
// ----------------------------------------------------------------------------
// complex_shifted_fir_filter_top
// Real or frequency-shifted complex FIR with memory-held taps and history.
// ----------------------------------------------------------------------------
// One sample at a time. A coefficient load is written as it is accepted and
// does not leave idle. A real sample is paced by the single read port of the
// tap and history memories (one tap a cycle, I and Q lanes side by side). A
// complex sample adds a CORDIC run and the down and up rotations on one
// shared multiplier. The next item is taken while a result still waits on
// the output. History that was never written reads as zero by a fill count,
// so no clearing pass is needed.
module complex_shifted_fir_filter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // coef_index[9:0], coef_value[27:10], sample_i[43:28], sample_q[59:44], zero
  input  logic [63:0] s_tdata,
  // cmd[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_i[15:0], out_q[31:16]
  output logic [31:0] m_tdata,
  // clipped[0]
  output logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import csff_pkg::*;

  state_t state, state_next;

  logic [TAP_CNT_BITS-1:0] num_taps, ntaps, k, fill;
  logic                    complex_mode;
  logic [31:0]             phase_step, phase_acc;
  logic [ADDR_BITS-1:0]    wp, haddr;

  logic signed [SAMPLE_BITS-1:0] si, sq, fi, fq, r0, r1;
  logic                          clip;

  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic [2*SAMPLE_BITS-1:0]      hist_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_rd;
  logic [2*SAMPLE_BITS-1:0]      hist_rd;
  logic signed [SAMPLE_BITS-1:0] hs_i, hs_q;

  logic issue, s1, s2, hv1;
  logic signed [PROD_BITS-1:0] prod_i, prod_q;
  logic signed [ACC_BITS-1:0]  acc_i, acc_q;

  logic [2:0]                    rstep;
  logic                          rot_up;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [TRIG_BITS-1:0]   mul_b;
  logic signed [SAMPLE_BITS+TRIG_BITS-1:0] rprod, racc;
  logic signed [RND_BITS-1:0]    rsum;
  logic [SAMPLE_BITS:0]          rres, fres_i, fres_q;

  logic     accept, nco_start;
  nco_out_t nco_out;

  csff_nco u_nco (
    .clk     (clk),
    .rst     (rst),
    .start   (nco_start),
    .phase   (phase_acc),
    .nco_out (nco_out)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign nco_start = accept && (s_tuser[0] == CMD_SAMPLE) && complex_mode;

  assign ntaps = (num_taps > TAP_CNT_BITS'(MAX_TAPS)) ? TAP_CNT_BITS'(MAX_TAPS) : num_taps;
  assign issue = (state == ST_FIR) && (k < ntaps);
  assign haddr = wp - k[ADDR_BITS-1:0];

  // Unwritten history reads as zero.
  assign hs_i = hv1 ? hist_rd[SAMPLE_BITS-1:0] : '0;
  assign hs_q = hv1 ? hist_rd[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;

  // Rotation operand select: down uses the input, up the filter output.
  always_comb begin
    mul_a = (rstep == 3'd0 || rstep == 3'd3) ? (rot_up ? fi : si) : (rot_up ? fq : sq);
    mul_b = rstep[0] ? nco_out.sin_v : nco_out.cos_v;
    if ((rstep == 3'd2) ? rot_up : !rot_up)
      rsum = RND_BITS'(racc) - RND_BITS'(rprod);
    else
      rsum = RND_BITS'(racc) + RND_BITS'(rprod);
    rres   = round_sat(rsum, NCO_FRAC);
    fres_i = round_sat(RND_BITS'(acc_i), COEF_BITS - 1);
    fres_q = round_sat(RND_BITS'(acc_q), COEF_BITS - 1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser[0] == CMD_SAMPLE)
          state_next = complex_mode ? ST_NCO : ST_WR_HIST;
      end
      ST_NCO:     if (nco_out.done) state_next = ST_ROT;
      ST_ROT:     if (rstep == 3'd4) state_next = rot_up ? ST_DONE : ST_WR_HIST;
      ST_WR_HIST: state_next = ST_FIR;
      ST_FIR: begin
        if (!issue && !s1 && !s2)
          state_next = complex_mode ? ST_ROT : ST_DONE;
      end
      ST_DONE:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser[0] == CMD_LOAD)
      coef_mem[s_tdata[ADDR_BITS-1:0]] <= s_tdata[ADDR_BITS+COEF_BITS-1:ADDR_BITS];
    coef_rd <= coef_mem[k[ADDR_BITS-1:0]];
    if (state == ST_WR_HIST)
      hist_mem[wp] <= complex_mode ? {r1, r0} : {{SAMPLE_BITS{1'b0}}, si};
    hist_rd <= hist_mem[haddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_taps     <= TAP_CNT_BITS'(1023);
      complex_mode <= 1'b0;
      phase_step   <= '0;
      phase_acc    <= '0;
      wp           <= '0;
      fill         <= '0;
      m_tvalid     <= 1'b0;
      s1           <= 1'b0;
      s2           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_TAPS:     num_taps <= cfg_data[TAP_CNT_BITS-1:0];
          REG_COMPLEX_MODE: complex_mode <= cfg_data[0];
          REG_PHASE_STEP:   phase_step <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;

      s1  <= issue;
      s2  <= s1;
      hv1 <= fill[ADDR_BITS] || ({1'b0, haddr} < fill);
      if (issue) k <= k + TAP_CNT_BITS'(1);
      if (s1) begin
        prod_i <= coef_rd * hs_i;
        prod_q <= coef_rd * hs_q;
      end
      if (s2) begin
        acc_i <= acc_i + ACC_BITS'(prod_i);
        acc_q <= acc_q + ACC_BITS'(prod_q);
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            si     <= s_tdata[43:28];
            sq     <= s_tdata[59:44];
            clip   <= 1'b0;
            rot_up <= 1'b0;
            rstep  <= '0;
          end
        end
        ST_ROT: begin
          rprod <= mul_a * mul_b;
          rstep <= rstep + 3'd1;
          if (rstep == 3'd1 || rstep == 3'd3) racc <= rprod;
          if (rstep == 3'd2) begin
            r0 <= rres[SAMPLE_BITS-1:0];
            clip <= clip | rres[SAMPLE_BITS];
          end
          if (rstep == 3'd4) begin
            r1 <= rres[SAMPLE_BITS-1:0];
            clip <= clip | rres[SAMPLE_BITS];
          end
        end
        ST_WR_HIST: begin
          if (!fill[ADDR_BITS]) fill <= fill + TAP_CNT_BITS'(1);
          k     <= '0;
          acc_i <= '0;
          acc_q <= '0;
        end
        ST_FIR: begin
          if (!issue && !s1 && !s2) begin
            fi     <= fres_i[SAMPLE_BITS-1:0];
            fq     <= fres_q[SAMPLE_BITS-1:0];
            clip   <= clip | fres_i[SAMPLE_BITS] | (complex_mode & fres_q[SAMPLE_BITS]);
            rot_up <= 1'b1;
            rstep  <= '0;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= clip;
            m_tdata  <= complex_mode ? {r1, r0} : {{SAMPLE_BITS{1'b0}}, fi};
            wp       <= wp + ADDR_BITS'(1);
            if (complex_mode) phase_acc <= phase_acc + phase_step;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/csff_checker.sv]
// ----------------------------------------------------------------------------
// csff_checker
// Port-level checks of the filter's sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module csff_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);
  import csff_pkg::*;

  // Out of reset: idle, nothing on the output.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  // A sample transfer leaves the block busy in the cycle after it.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] == CMD_SAMPLE |=> !s_tready)
    else $error("input taken while a sample is in progress");

  // A result arrives only while the block is busy finishing a sample.
  a_src: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid ##1 m_tvalid |-> !$past(s_tready))
    else $error("result appeared from idle");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind complex_shifted_fir_filter_top csff_checker u_csff_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
